// ===== rtl/owtr_pkg.sv =====
package owtr_pkg;

  localparam int unsigned TickW = 20;
  localparam int unsigned TickSumW = TickW + 1;
  localparam logic [TickW-1:0] ConvWaitReset = 20'd750000;

  localparam int unsigned ScratchBytes = 9;

  localparam int unsigned RstLowTicks = 480;
  localparam int unsigned RstHighTicks = 15;
  localparam int unsigned PresLowLimit = 200;
  localparam int unsigned PresHighLimit = 240;
  localparam int unsigned SlotLowTicks = 2;
  localparam int unsigned WriteHoldTicks = 60;
  localparam int unsigned WriteSlotTicks = 63;
  localparam int unsigned ReadSampleTick = 14;
  localparam int unsigned ReadSlotTicks = 64;

  localparam logic [7:0] CmdSkipRom = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdReadPad = 8'hBE;

  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [4:0] {
    PhIdle      = 5'd0,
    PhARstLow   = 5'd1,
    PhARstHigh  = 5'd2,
    PhAPresLow  = 5'd3,
    PhAPresHigh = 5'd4,
    PhAWrite    = 5'd5,
    PhConvWait  = 5'd6,
    PhBRstLow   = 5'd7,
    PhBRstHigh  = 5'd8,
    PhBPresLow  = 5'd9,
    PhBPresHigh = 5'd10,
    PhBWrite    = 5'd11,
    PhRead      = 5'd12
  } phase_e;

  typedef struct packed {
    logic start_req;
    logic line_level;
  } tick_t;

  typedef struct packed {
    logic               no_device;
    logic signed [15:0] temperature_tenths;
    logic               temp_valid;
    logic               busy_res;
    logic               drive_low;
  } result_t;

  // sign-magnitude times 0.625, truncated toward zero
  function automatic logic [15:0] to_tenths(input logic [15:0] raw);
    logic [15:0] mag;
    logic [18:0] prod;
    logic [15:0] scaled;
    mag = raw[15] ? (~raw + 16'd1) : raw;
    prod = {1'b0, mag, 2'b00} + {3'b000, mag};
    scaled = prod[18:3];
    return raw[15] ? (~scaled + 16'd1) : scaled;
  endfunction

endpackage

// ===== rtl/one_wire_temperature_reader_top.sv =====
// channel   | dir | handshake                          | payload
// s_axis    | in  | s_axis_tvalid_i / s_axis_tready_o  | one bus tick request
// m_axis    | out | m_axis_tvalid_o / m_axis_tready_i  | one result per tick
// cfg       | in  | cfg_valid_i / cfg_ready_o          | conversion wait ticks
//
// one tick request per cycle unless the output stalls; a request is registered,
// the bus step runs combinationally from it into the output register
// rst_ni clears sequencer state, flags, last temperature, wait = 750000
// a stalled output holds its result; input stalls only when both registers are full
module one_wire_temperature_reader_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] start_req, [1] line_level, [7:2] zero
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] drive_low, [1] busy_res, [2] temp_valid, [18:3] temperature_tenths,
  // [19] no_device, [23:20] zero
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i
);
  import owtr_pkg::*;

  logic [TickW-1:0] conv_wait_q;
  tick_t            in_tick;
  tick_t            reg_tick;
  logic             reg_valid;
  logic             out_ready;
  logic             fire;
  result_t          core_res;
  result_t          out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_wait_q <= ConvWaitReset;
    end else if (cfg_valid_i) begin
      conv_wait_q <= cfg_data_i;
    end
  end

  assign in_tick.start_req = s_axis_tdata_i[0];
  assign in_tick.line_level = s_axis_tdata_i[1];
  assign fire = reg_valid && out_ready;

  owtr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .tick_i  (in_tick),
    .valid_o (reg_valid),
    .adv_i   (fire),
    .tick_o  (reg_tick)
  );

  owtr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .tick_i      (reg_tick),
    .conv_wait_i (conv_wait_q),
    .result_o    (core_res)
  );

  owtr_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .ready_o  (out_ready),
    .result_i (core_res),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {4'b0000, out_res.no_device, out_res.temperature_tenths,
                           out_res.temp_valid, out_res.busy_res, out_res.drive_low};
endmodule

// ===== rtl/owtr_in_reg.sv =====
module owtr_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  owtr_pkg::tick_t tick_i,
  output logic            valid_o,
  input  logic            adv_i,
  output owtr_pkg::tick_t tick_o
);
  import owtr_pkg::*;

  logic  vld_q, vld_d;
  tick_t tick_q;

  assign ready_o = !vld_q || adv_i;
  assign vld_d = (valid_i && ready_o) ? 1'b1 : (adv_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tick_q <= tick_i;
    end
  end

  assign valid_o = vld_q;
  assign tick_o = tick_q;
endmodule

// ===== rtl/owtr_core.sv =====
module owtr_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  owtr_pkg::tick_t           tick_i,
  input  logic [owtr_pkg::TickW-1:0] conv_wait_i,
  output owtr_pkg::result_t         result_o
);
  import owtr_pkg::*;

  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [2:0]        bit_q, bit_d;
  logic [3:0]        byte_q, byte_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        raw_low_q, raw_low_d;
  logic [7:0]        raw_high_q, raw_high_d;
  logic              pfail_q, pfail_d;
  logic [15:0]       temp_q, temp_d;

  logic [TickSumW-1:0] tick_plus;
  logic [TickW-1:0]    tick_inc;
  logic [2:0]          bit_inc;
  logic [3:0]          byte_inc;
  logic                drive;
  logic                valid;

  assign tick_plus = {1'b0, tick_q} + TickSumW'(1);
  assign tick_inc = tick_plus[TickW-1:0];
  assign bit_inc = bit_q + 3'd1;
  assign byte_inc = byte_q + 4'd1;

  always_comb begin
    phase_d = phase_q;
    tick_d = tick_q;
    bit_d = bit_q;
    byte_d = byte_q;
    shift_d = shift_q;
    raw_low_d = raw_low_q;
    raw_high_d = raw_high_q;
    pfail_d = pfail_q;
    temp_d = temp_q;
    drive = 1'b0;
    valid = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        if (tick_i.start_req) begin
          pfail_d = 1'b0;
          phase_d = PhARstLow;
          tick_d = '0;
        end
      end
      PhARstLow, PhBRstLow: begin
        drive = 1'b1;
        if (tick_plus >= TickSumW'(RstLowTicks)) begin
          phase_d = (phase_q == PhARstLow) ? PhARstHigh : PhBRstHigh;
          tick_d = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhARstHigh, PhBRstHigh: begin
        if (tick_plus >= TickSumW'(RstHighTicks)) begin
          phase_d = (phase_q == PhARstHigh) ? PhAPresLow : PhBPresLow;
          tick_d = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhAPresLow, PhBPresLow: begin
        if (!tick_i.line_level) begin
          phase_d = (phase_q == PhAPresLow) ? PhAPresHigh : PhBPresHigh;
          tick_d = '0;
        end else if (tick_plus >= TickSumW'(PresLowLimit)) begin
          pfail_d = 1'b1;
          phase_d = (phase_q == PhAPresLow) ? PhAWrite : PhBWrite;
          tick_d = '0;
          bit_d = '0;
          byte_d = '0;
          shift_d = CmdSkipRom;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhAPresHigh, PhBPresHigh: begin
        if (tick_i.line_level || (tick_plus >= TickSumW'(PresHighLimit))) begin
          if (!tick_i.line_level) begin
            pfail_d = 1'b1;
          end
          phase_d = (phase_q == PhAPresHigh) ? PhAWrite : PhBWrite;
          tick_d = '0;
          bit_d = '0;
          byte_d = '0;
          shift_d = CmdSkipRom;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhAWrite, PhBWrite: begin
        if (tick_q < TickW'(SlotLowTicks)) begin
          drive = 1'b1;
        end else if (tick_q < TickW'(SlotLowTicks + WriteHoldTicks)) begin
          drive = ~shift_q[0];
        end
        if (tick_plus >= TickSumW'(WriteSlotTicks)) begin
          tick_d = '0;
          shift_d = {1'b0, shift_q[7:1]};
          bit_d = bit_inc;
          if (bit_inc == 3'd0) begin
            byte_d = byte_inc;
            if (byte_inc >= 4'd2) begin
              if (phase_q == PhAWrite) begin
                phase_d = PhConvWait;
              end else begin
                phase_d = PhRead;
                bit_d = '0;
                byte_d = '0;
                shift_d = '0;
              end
            end else begin
              shift_d = (phase_q == PhAWrite) ? CmdConvert : CmdReadPad;
            end
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      PhConvWait: begin
        if (tick_plus >= {1'b0, conv_wait_i}) begin
          phase_d = PhBRstLow;
          tick_d = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhRead: begin
        if (tick_q < TickW'(SlotLowTicks)) begin
          drive = 1'b1;
        end
        if (tick_q == TickW'(ReadSampleTick)) begin
          shift_d = {tick_i.line_level, shift_q[7:1]};
        end
        if (tick_plus >= TickSumW'(ReadSlotTicks)) begin
          tick_d = '0;
          bit_d = bit_inc;
          if (bit_inc == 3'd0) begin
            if (byte_q == 4'd0) begin
              raw_low_d = shift_q;
            end else if (byte_q == 4'd1) begin
              raw_high_d = shift_q;
            end
            byte_d = byte_inc;
            if (byte_inc >= 4'(ScratchBytes)) begin
              temp_d = to_tenths({raw_high_d, raw_low_d});
              valid = 1'b1;
              phase_d = PhIdle;
            end
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q <= '0;
      bit_q <= '0;
      byte_q <= '0;
      shift_q <= '0;
      raw_low_q <= '0;
      raw_high_q <= '0;
      pfail_q <= 1'b0;
      temp_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      tick_q <= tick_d;
      bit_q <= bit_d;
      byte_q <= byte_d;
      shift_q <= shift_d;
      raw_low_q <= raw_low_d;
      raw_high_q <= raw_high_d;
      pfail_q <= pfail_d;
      temp_q <= temp_d;
    end
  end

  always_comb begin
    result_o.drive_low = drive;
    result_o.busy_res = (phase_d != PhIdle);
    result_o.temp_valid = valid;
    result_o.temperature_tenths = temp_d;
    result_o.no_device = pfail_d;
  end
endmodule

// ===== rtl/owtr_out_reg.sv =====
module owtr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  output logic              ready_o,
  input  owtr_pkg::result_t result_i,
  output logic              valid_o,
  input  logic              ready_i,
  output owtr_pkg::result_t result_o
);
  import owtr_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign ready_o = !vld_q || ready_i;
  assign vld_d = load_i ? 1'b1 : (ready_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign valid_o = vld_q;
  assign result_o = res_q;
endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import owtr_pkg::*;

  localparam int unsigned CmdBytes = 2;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TotalTicks = 1800;
  localparam int unsigned QuietTicks = 200;
  localparam int unsigned ScaleChecks = 64;

  typedef enum {PresNormal, PresAbsent, PresStuck} pres_mode_e;

  class bus_scoreboard;
    logic [TickW-1:0] conv_wait;
    phase_e           phase;
    logic [TickW-1:0] tick_count;
    logic [2:0]       bit_index;
    logic [3:0]       byte_index;
    logic [7:0]       shift_byte;
    logic [7:0]       raw_low;
    logic [7:0]       raw_high;
    logic             presence_failed;
    logic [15:0]      last_temperature;
    result_t          expected_ticks[$];
    int unsigned      errors;

    function new();
      conv_wait = ConvWaitReset;
      phase = PhIdle;
      tick_count = '0;
      bit_index = '0;
      byte_index = '0;
      shift_byte = '0;
      raw_low = '0;
      raw_high = '0;
      presence_failed = 1'b0;
      last_temperature = '0;
      errors = 0;
    endfunction

    function void set_conv_wait(logic [TickW-1:0] value);
      conv_wait = value;
    endfunction

    function logic [15:0] scale_tenths(logic [15:0] raw);
      logic [15:0] mag;
      int unsigned scaled;
      mag = raw[15] ? 16'(~raw + 16'd1) : raw;
      scaled = (32'(mag) * 32'd5) >> 3;
      return raw[15] ? 16'(32'd0 - scaled) : 16'(scaled);
    endfunction

    function void enter(phase_e next_phase);
      phase = next_phase;
      tick_count = '0;
    endfunction

    function void begin_command(phase_e next_phase);
      enter(next_phase);
      bit_index = '0;
      byte_index = '0;
      shift_byte = CmdSkipRom;
    endfunction

    // one bus tick, queues the result it produces
    function void note_tick(logic start, logic lvl);
      result_t r;
      logic [TickSumW-1:0] next_count;
      logic drive;
      logic valid;
      next_count = {1'b0, tick_count} + TickSumW'(1);
      drive = 1'b0;
      valid = 1'b0;
      case (phase)
        PhIdle: begin
          if (start) begin
            presence_failed = 1'b0;
            enter(PhARstLow);
          end
        end
        PhARstLow, PhBRstLow: begin
          drive = 1'b1;
          if (next_count >= TickSumW'(RstLowTicks)) enter(phase_e'(phase + 1));
          else tick_count = next_count[TickW-1:0];
        end
        PhARstHigh, PhBRstHigh: begin
          if (next_count >= TickSumW'(RstHighTicks)) enter(phase_e'(phase + 1));
          else tick_count = next_count[TickW-1:0];
        end
        PhAPresLow, PhBPresLow: begin
          if (!lvl) begin
            enter(phase_e'(phase + 1));
          end else if (next_count >= TickSumW'(PresLowLimit)) begin
            presence_failed = 1'b1;
            begin_command(phase_e'(phase + 2));
          end else begin
            tick_count = next_count[TickW-1:0];
          end
        end
        PhAPresHigh, PhBPresHigh: begin
          if (lvl) begin
            begin_command(phase_e'(phase + 1));
          end else if (next_count >= TickSumW'(PresHighLimit)) begin
            presence_failed = 1'b1;
            begin_command(phase_e'(phase + 1));
          end else begin
            tick_count = next_count[TickW-1:0];
          end
        end
        PhAWrite, PhBWrite: begin
          if (tick_count < TickW'(SlotLowTicks)) drive = 1'b1;
          else if (tick_count < TickW'(SlotLowTicks + WriteHoldTicks)) drive = ~shift_byte[0];
          if (next_count >= TickSumW'(WriteSlotTicks)) begin
            tick_count = '0;
            shift_byte = shift_byte >> 1;
            bit_index = bit_index + 3'd1;
            if (bit_index == 3'd0) begin
              byte_index = byte_index + 4'd1;
              if (byte_index >= 4'(CmdBytes)) begin
                if (phase == PhAWrite) begin
                  enter(PhConvWait);
                end else begin
                  enter(PhRead);
                  bit_index = '0;
                  byte_index = '0;
                  shift_byte = '0;
                end
              end else begin
                shift_byte = (phase == PhAWrite) ? CmdConvert : CmdReadPad;
              end
            end
          end else begin
            tick_count = next_count[TickW-1:0];
          end
        end
        PhConvWait: begin
          if (next_count >= {1'b0, conv_wait}) enter(PhBRstLow);
          else tick_count = next_count[TickW-1:0];
        end
        PhRead: begin
          if (tick_count < TickW'(SlotLowTicks)) drive = 1'b1;
          if (tick_count == TickW'(ReadSampleTick)) shift_byte = {lvl, shift_byte[7:1]};
          if (next_count >= TickSumW'(ReadSlotTicks)) begin
            tick_count = '0;
            bit_index = bit_index + 3'd1;
            if (bit_index == 3'd0) begin
              if (byte_index == 4'd0) raw_low = shift_byte;
              else if (byte_index == 4'd1) raw_high = shift_byte;
              byte_index = byte_index + 4'd1;
              if (byte_index >= 4'(ScratchBytes)) begin
                last_temperature = scale_tenths({raw_high, raw_low});
                valid = 1'b1;
                enter(PhIdle);
              end
            end
          end else begin
            tick_count = next_count[TickW-1:0];
          end
        end
        default: enter(PhIdle);
      endcase
      r.drive_low = drive;
      r.busy_res = (phase != PhIdle);
      r.temp_valid = valid;
      r.temperature_tenths = last_temperature;
      r.no_device = presence_failed;
      expected_ticks.push_back(r);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_tick(logic [OutDataW-1:0] data);
      result_t want;
      result_t got;
      got = result_t'(data[$bits(result_t)-1:0]);
      if (expected_ticks.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %h", $time, data);
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("drive_low", want.drive_low, got.drive_low);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("temp_valid", want.temp_valid, got.temp_valid);
      compare_field("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
      compare_field("no_device", want.no_device, got.no_device);
      compare_field("padding", 0, int'(data[OutDataW-1:$bits(result_t)]));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [19:0] cfg_data_i = '0;

  bus_scoreboard sb;
  bit            idling_on = 1'b1;
  int unsigned   sent_count;

  pres_mode_e  pres_mode [2];
  int unsigned low_delay [2];
  int unsigned high_delay [2];
  logic [7:0]  pad [ScratchBytes];
  int unsigned noise_pct;

  one_wire_temperature_reader_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sensor side of the bus, follows the sequencer state
  function automatic logic sensor_level();
    int pass;
    pass = (sb.phase >= PhBRstLow) ? 1 : 0;
    if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) return 1'($urandom_range(0, 1));
    case (sb.phase)
      PhIdle: return 1'($urandom_range(0, 1));
      PhARstLow, PhBRstLow: return 1'b0;
      PhAPresLow, PhBPresLow: begin
        if (pres_mode[pass] == PresAbsent) return 1'b1;
        if (pres_mode[pass] == PresStuck) return 1'b0;
        return (sb.tick_count >= TickW'(low_delay[pass])) ? 1'b0 : 1'b1;
      end
      PhAPresHigh, PhBPresHigh:
        return pres_mode[pass] == PresNormal && sb.tick_count >= TickW'(high_delay[pass]);
      PhRead: begin
        if (sb.tick_count < TickW'(SlotLowTicks)) return 1'b0;
        if (sb.tick_count <= TickW'(ReadSampleTick)) return pad[sb.byte_index][sb.bit_index];
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  task automatic send_tick(logic start, logic lvl);
    s_axis_tdata_i <= {6'd0, lvl, start};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_tick(start, lvl);
    sent_count++;
    if (idling_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic idle_ticks(int n);
    repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_ticks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_wait(logic [19:0] value);
    drain();
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_conv_wait(value);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_tick(m_axis_tdata_o);
  end

  initial begin
    repeat (7) @(posedge clk_i);
    m_axis_tready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [15:0] raw;
    logic [15:0] want;
    logic [15:0] got;
    sb = new();
    noise_pct = 0;
    sent_count = 0;
    pres_mode = '{PresAbsent, PresNormal};
    low_delay = '{0, 20};
    high_delay = '{0, 40};
    for (int i = 0; i < ScratchBytes; i++) pad[i] = 8'($urandom);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tenths scaling on corner and random raw values
    for (int i = 0; i < ScaleChecks; i++) begin
      case (i)
        0: raw = 16'h8000;
        1: raw = 16'h7FFF;
        2: raw = 16'hFFFF;
        3: raw = 16'h0001;
        4: raw = 16'h0000;
        5: raw = 16'hFC90;
        default: raw = 16'($urandom);
      endcase
      want = sb.scale_tenths(raw);
      got = to_tenths(raw);
      if (want != got) begin
        $display("%0t: tenths of %h expected %0d actual %0d", $time, raw,
                 $signed(want), $signed(got));
        sb.errors++;
      end
    end

    // register at its reset value, then rewritten, no measurement
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    idle_ticks(4);
    write_wait(20'd1000000);
    idle_ticks(2);
    write_wait(20'd1);
    idle_ticks(2);

    // missing device on the first reset, both command bytes, shortest conversion wait
    noise_pct = 2;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    // start requests while busy must be ignored
    while (sent_count < TotalTicks) begin
      if (sent_count >= TotalTicks - QuietTicks) idling_on = 1'b0;
      send_tick(1'($urandom_range(0, 1)), sensor_level());
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== one_wire_temperature_reader_top.f =====
rtl/owtr_pkg.sv
rtl/owtr_in_reg.sv
rtl/owtr_core.sv
rtl/owtr_out_reg.sv
rtl/one_wire_temperature_reader_top.sv
sim/tb_top.sv
